// File: rtl/core/wht_pkg.sv
`default_nettype none
package wht_pkg;

   localparam int VALUE_W = 30;
   localparam int OP_W = 2;
   localparam logic [VALUE_W-1:0] MOD_P = 30'd1000000007;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_TRANSFORM = 2'd1;
   localparam logic [OP_W-1:0] OP_READ = 2'd2;

   localparam int MUL_CNT_W = $clog2(VALUE_W);
   localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(VALUE_W - 1);

   // one conditional subtract: x < 2P in, residue out
   function automatic logic [VALUE_W-1:0] mod_fold(input logic [VALUE_W:0] x);
      logic [VALUE_W:0] d;
      d = x - {1'b0, MOD_P};
      return (x >= {1'b0, MOD_P}) ? d[VALUE_W-1:0] : x[VALUE_W-1:0];
   endfunction

   function automatic logic [VALUE_W-1:0] mod_add(input logic [VALUE_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
      return mod_fold({1'b0, a} + {1'b0, b});
   endfunction

   function automatic logic [VALUE_W-1:0] mod_sub(input logic [VALUE_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
      logic [VALUE_W:0] d;
      d = {1'b0, a} + {1'b0, MOD_P} - {1'b0, b};
      return (a >= b) ? (a - b) : d[VALUE_W-1:0];
   endfunction

   // inverse of 2^log_size mod P by repeated halving
   function automatic logic [VALUE_W-1:0] inv_pow2(input int log_size);
      logic [VALUE_W:0] x;
      x = (VALUE_W+1)'(1);
      for (int i = 0; i < 16; i++) begin
         if (i < log_size) begin
            x = x[0] ? ((x + {1'b0, MOD_P}) >> 1) : (x >> 1);
         end
      end
      return x[VALUE_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/walsh_hadamard_transform_mod_prime_core.sv
`default_nettype none
// Channel  | Handshake                      | Payload
// request  | start, busy (taken: start&!busy) | req_opcode, req_index, req_value
// response | rsp_valid (one-cycle strobe)   | rsp_read_value, rsp_done_kind
// config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
// Write, read and unused opcodes: busy stays low, result strobed the next cycle, so one
// transaction per cycle while no transform runs. Transform: each butterfly reads a pair,
// then writes a and b through the single write port of the element store; inverse mode
// then scales each element with the 30-step shared modular multiplier. Synchronous reset
// clears control only; the store is undefined until written. Results cannot be stalled.
module walsh_hadamard_transform_mod_prime_core
   import wht_pkg::*;
#(
   parameter int LOG_SIZE = 10
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [OP_W-1:0]    req_opcode,
   input  wire logic [9:0]         req_index,
   input  wire logic [VALUE_W-1:0] req_value,
   output logic                    rsp_valid,
   output logic [VALUE_W-1:0]      rsp_read_value,
   output logic [OP_W-1:0]         rsp_done_kind,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int ADDR_W = LOG_SIZE;
   localparam int SIZE = 1 << LOG_SIZE;
   localparam int STAGE_W = $clog2(LOG_SIZE + 1);
   localparam logic [ADDR_W-1:0] HALF_LAST = ADDR_W'((SIZE / 2) - 1);
   localparam logic [ADDR_W-1:0] ELEM_LAST = ADDR_W'(SIZE - 1);
   localparam logic [STAGE_W-1:0] STAGE_LAST = STAGE_W'(LOG_SIZE - 1);
   localparam logic [VALUE_W-1:0] INV_SCALE = inv_pow2(LOG_SIZE);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_BF_RD = 3'd1;
   localparam logic [2:0] ST_BF_WA = 3'd2;
   localparam logic [2:0] ST_BF_WB = 3'd3;
   localparam logic [2:0] ST_SC_RD = 3'd4;
   localparam logic [2:0] ST_SC_GO = 3'd5;
   localparam logic [2:0] ST_SC_WAIT = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic [ADDR_W-1:0]  bfly_ff, bfly_in;
   logic [ADDR_W-1:0]  elem_ff, elem_in;
   logic               inverse_ff, inverse_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OP_W-1:0]    rsp_kind_ff, rsp_kind_in;

   logic [VALUE_W-1:0] store [SIZE];
   logic [VALUE_W-1:0] rd_a_ff;
   logic [VALUE_W-1:0] rd_b_ff;

   logic                   accept;
   logic                   csr_write;
   logic [ADDR_W+9:0]      index_ext;
   logic [ADDR_W-1:0]      req_addr;
   logic [ADDR_W-1:0]      stage_mask;
   logic [ADDR_W-1:0]      stage_bit;
   logic [ADDR_W-1:0]      addr_a;
   logic [ADDR_W-1:0]      addr_b;
   logic [ADDR_W-1:0]      raddr_a;
   logic                   rd_en;
   logic                   mem_we;
   logic [ADDR_W-1:0]      mem_waddr;
   logic [VALUE_W-1:0]     mem_wdata;
   logic                   mul_start;
   logic                   mul_busy;
   logic                   mul_done;
   logic [VALUE_W-1:0]     mul_result;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign index_ext = {{ADDR_W{1'b0}}, req_index};
   assign req_addr = index_ext[ADDR_W-1:0];

   // butterfly pair: insert a zero (a) or one (b) at bit 'stage' of the counter
   always_comb begin
      for (int i = 0; i < ADDR_W; i++) begin
         stage_mask[i] = (STAGE_W'(i) < stage_ff);
         stage_bit[i] = (STAGE_W'(i) == stage_ff);
      end
      addr_a = ((bfly_ff & ~stage_mask) << 1) | (bfly_ff & stage_mask);
      addr_b = addr_a | stage_bit;
   end

   always_comb begin
      unique case (state_ff)
         ST_BF_RD, ST_BF_WA, ST_BF_WB: raddr_a = addr_a;
         ST_SC_RD, ST_SC_GO, ST_SC_WAIT: raddr_a = elem_ff;
         default: raddr_a = req_addr;
      endcase
   end

   assign rd_en = (state_ff == ST_IDLE) || (state_ff == ST_BF_RD) || (state_ff == ST_SC_RD);

   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      bfly_in = bfly_ff;
      elem_in = elem_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      mem_we = 1'b0;
      mem_waddr = req_addr;
      mem_wdata = mod_fold({1'b0, req_value});
      mul_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_kind_in = req_opcode;
               if (req_opcode == OP_TRANSFORM) begin
                  state_in = ST_BF_RD;
                  stage_in = '0;
                  bfly_in = '0;
               end else begin
                  rsp_valid_in = 1'b1;
                  mem_we = (req_opcode == OP_WRITE);
               end
            end
         end
         ST_BF_RD: begin
            state_in = ST_BF_WA;
         end
         ST_BF_WA: begin
            mem_we = 1'b1;
            mem_waddr = addr_a;
            mem_wdata = mod_add(rd_a_ff, rd_b_ff);
            state_in = ST_BF_WB;
         end
         ST_BF_WB: begin
            mem_we = 1'b1;
            mem_waddr = addr_b;
            mem_wdata = mod_sub(rd_a_ff, rd_b_ff);
            state_in = ST_BF_RD;
            bfly_in = bfly_ff + 1'b1;
            if (bfly_ff == HALF_LAST) begin
               bfly_in = '0;
               stage_in = stage_ff + 1'b1;
               if (stage_ff == STAGE_LAST) begin
                  if (inverse_ff) begin
                     state_in = ST_SC_RD;
                     elem_in = '0;
                  end else begin
                     state_in = ST_IDLE;
                     rsp_valid_in = 1'b1;
                  end
               end
            end
         end
         ST_SC_RD: begin
            state_in = ST_SC_GO;
         end
         ST_SC_GO: begin
            mul_start = 1'b1;
            state_in = ST_SC_WAIT;
         end
         ST_SC_WAIT: begin
            if (mul_done) begin
               mem_we = 1'b1;
               mem_waddr = elem_ff;
               mem_wdata = mul_result;
               elem_in = elem_ff + 1'b1;
               state_in = ST_SC_RD;
               if (elem_ff == ELEM_LAST) begin
                  state_in = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_a_ff <= store[raddr_a];
         rd_b_ff <= store[addr_b];
      end
   end

   wht_modmul u_modmul (
      .clock      (clock),
      .reset      (reset),
      .mul_start  (mul_start),
      .mul_a      (rd_a_ff),
      .mul_b      (INV_SCALE),
      .mul_busy   (mul_busy),
      .mul_done   (mul_done),
      .mul_result (mul_result)
   );

   // only the first word holds a register; bits [1:0] are byte lanes
   assign csr_write = psel && penable && pwrite && pready;
   assign inverse_in = (csr_write && !paddr[2]) ? pwdata[0] : inverse_ff;
   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {31'd0, inverse_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         inverse_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         inverse_ff <= inverse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stage_ff <= stage_in;
      bfly_ff <= bfly_in;
      elem_ff <= elem_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_done_kind = rsp_kind_ff;
   assign rsp_read_value = (rsp_kind_ff == OP_READ) ? rd_a_ff : '0;

`ifndef SYNTH
   a_transform_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_TRANSFORM) |=> busy)
      else $error("transform transaction did not raise busy");

   a_transform_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_kind == OP_TRANSFORM) |-> $past(busy))
      else $error("transform result without a preceding busy period");

   a_mul_not_restarted: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_busy)
      else $error("multiplier started while still running");

   a_no_accept_when_scaling: assert property (@(posedge clock) disable iff (reset)
      mul_busy |-> (state_ff == ST_SC_WAIT))
      else $error("multiplier running outside the scaling wait state");
`endif

endmodule
`default_nettype wire

// File: rtl/core/wht_modmul.sv
`default_nettype none
module wht_modmul
   import wht_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               mul_start,
   input  wire logic [VALUE_W-1:0] mul_a,
   input  wire logic [VALUE_W-1:0] mul_b,
   output logic                    mul_busy,
   output logic                    mul_done,
   output logic [VALUE_W-1:0]      mul_result
);

   // shift-and-add, multiplier bits taken MSB first, one bit a cycle
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VALUE_W-1:0]   acc_ff, acc_in;
   logic [VALUE_W-1:0]   a_ff, a_in;
   logic [VALUE_W-1:0]   b_ff, b_in;
   logic [VALUE_W-1:0]   dbl;
   logic [VALUE_W-1:0]   addend;

   always_comb begin
      dbl = mod_fold({acc_ff, 1'b0});
      addend = b_ff[VALUE_W-1] ? a_ff : '0;
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      a_in = a_ff;
      b_in = b_ff;
      if (mul_start) begin
         run_in = 1'b1;
         cnt_in = '0;
         acc_in = '0;
         a_in = mul_a;
         b_in = mul_b;
      end else if (run_ff) begin
         acc_in = mod_add(dbl, addend);
         b_in = {b_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_LAST) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign mul_busy = run_ff;
   assign mul_done = done_ff;
   assign mul_result = acc_ff;

endmodule
`default_nettype wire

// File: dv/wht_check_pkg.sv
`timescale 1ns / 1ps
package wht_check_pkg;
   import wht_pkg::*;

   localparam logic [63:0] PRIME = 64'(MOD_P);

   typedef struct packed {
      logic [VALUE_W-1:0] read_value;
      logic [OP_W-1:0]    done_kind;
   } wht_reply_type;

   class wht_checker_type #(int LOG_SIZE = 10);
      localparam int SIZE = 1 << LOG_SIZE;

      logic [VALUE_W-1:0] residues[SIZE];
      logic [VALUE_W-1:0] inv_length;
      bit                 inverse_mode;
      wht_reply_type      expected_replies[$];
      int                 errors;
      int                 checked;

      function new();
         inverse_mode = 1'b0;
         errors = 0;
         checked = 0;
         foreach (residues[i]) residues[i] = '0;
         // Fermat: SIZE^(P-2) is the inverse of SIZE
         inv_length = VALUE_W'(pow_mod(64'(SIZE), PRIME - 64'd2));
      endfunction

      static function logic [63:0] pow_mod(logic [63:0] base, logic [63:0] ex);
         logic [63:0] acc;
         acc = 64'd1;
         base = base % PRIME;
         while (ex != 0) begin
            if (ex[0]) acc = (acc * base) % PRIME;
            base = (base * base) % PRIME;
            ex = ex >> 1;
         end
         return acc;
      endfunction

      function void butterfly_network();
         logic [63:0] a, b, s;
         for (int half = 1; half < SIZE; half = half * 2) begin
            for (int grp = 0; grp < SIZE; grp += 2 * half) begin
               for (int k = 0; k < half; k++) begin
                  a = 64'(residues[grp + k]);
                  b = 64'(residues[grp + k + half]);
                  s = a + b;
                  if (s >= PRIME) s = s - PRIME;
                  residues[grp + k] = VALUE_W'(s);
                  residues[grp + k + half] = (a >= b) ? VALUE_W'(a - b) : VALUE_W'(a + PRIME - b);
               end
            end
         end
         if (inverse_mode) begin
            foreach (residues[i]) begin
               residues[i] = VALUE_W'((64'(residues[i]) * 64'(inv_length)) % PRIME);
            end
         end
      endfunction

      // accepted request transaction: update the vector, queue the reply it causes
      function void note_request(logic [OP_W-1:0] op, logic [9:0] idx,
                                 logic [VALUE_W-1:0] val);
         wht_reply_type       r;
         logic [LOG_SIZE-1:0] pos;
         logic [VALUE_W-1:0]  v;
         pos = LOG_SIZE'(idx);
         r.read_value = '0;
         r.done_kind = op;
         unique case (op)
            OP_WRITE: begin
               v = val;
               if (v >= MOD_P) v = v - MOD_P;
               residues[pos] = v;
            end
            OP_TRANSFORM: begin
               butterfly_network();
            end
            OP_READ: begin
               r.read_value = residues[pos];
            end
            default: begin
            end
         endcase
         expected_replies = {expected_replies, r};
      endfunction

      function void check_response(logic [VALUE_W-1:0] rv, logic [OP_W-1:0] kind);
         wht_reply_type e;
         if (expected_replies.size() == 0) begin
            errors++;
            $display("%0t: reply with none outstanding: read_value %0d done_kind %0d",
                     $time, rv, kind);
            return;
         end
         e = expected_replies.pop_front();
         checked++;
         if (rv !== e.read_value) begin
            errors++;
            $display("%0t: wrong read_value: expected %0d actual %0d", $time,
                     e.read_value, rv);
         end
         if (kind !== e.done_kind) begin
            errors++;
            $display("%0t: wrong done_kind: expected %0d actual %0d", $time,
                     e.done_kind, kind);
         end
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction
   endclass

endpackage

// File: dv/tb_walsh_hadamard_transform_mod_prime_core.sv
`timescale 1ns / 1ps
module tb_walsh_hadamard_transform_mod_prime_core;
   import wht_pkg::*;
   import wht_check_pkg::*;

   localparam int LOG_SIZE = 10;
   localparam int SIZE = 1 << LOG_SIZE;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [2:0] CSR_INVERSE_MODE = 3'd0;
   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
   localparam int TRANSFORM_BUDGET = 12;
   localparam int MIXED_PHASES = 4;
   localparam int MIXED_PHASE_ITEMS = 250;
   localparam longint LIMIT_CYCLES = 3000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [OP_W-1:0]    req_opcode = OP_WRITE;
   logic [9:0]         req_index = '0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic               busy;
   logic               rsp_valid;
   logic [VALUE_W-1:0] rsp_read_value;
   logic [OP_W-1:0]    rsp_done_kind;
   logic [31:0]        prdata;
   logic               pready;

   walsh_hadamard_transform_mod_prime_core #(
      .LOG_SIZE(LOG_SIZE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_index(req_index),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_read_value(rsp_read_value),
      .rsp_done_kind(rsp_done_kind),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   wht_checker_type #(LOG_SIZE) vector_model;
   bit     written[SIZE];
   bit     cur_mode;
   int     calm_left;
   int     transforms_left;
   int     csr_errors;
   int     n_write, n_read, n_unused, n_plain_tf, n_scaled_tf, n_csr_write;
   longint cycles;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("walsh_hadamard_transform_mod_prime_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) vector_model.check_response(rsp_read_value, rsp_done_kind);
   end

   // mostly random gaps, with the odd stretch of back-to-back transactions
   function automatic int draw_gap();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
      return $urandom_range(0, 9);
   endfunction

   function automatic logic [VALUE_W-1:0] rand_value();
      unique case ($urandom_range(0, 9))
         0: return '0;
         1: return MOD_P - 30'd1;
         2: return VALUE_W'($urandom_range(32'(MOD_P), 32'h3FFF_FFFF));
         3: return VALUE_MAX;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // entered and left just after a rising edge
   task automatic send_item(input logic [OP_W-1:0] op, input logic [9:0] idx,
                            input logic [VALUE_W-1:0] val);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_index <= idx;
      req_value <= val;
      do @(posedge clock); while (busy);
      vector_model.note_request(op, idx, val);
      unique case (op)
         OP_WRITE: begin
            n_write++;
            written[idx] = 1'b1;
         end
         OP_TRANSFORM: begin
            if (cur_mode) n_scaled_tf++;
            else n_plain_tf++;
         end
         OP_READ: n_read++;
         default: n_unused++;
      endcase
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (vector_model.pending() != 0);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      n_csr_write++;
   endtask

   task automatic csr_check(input logic [2:0] addr, input logic [31:0] want);
      logic [31:0] got;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (got !== want) begin
         csr_errors++;
         $display("%0t: wrong prdata at %0d: expected %0h actual %0h", $time, addr, want, got);
      end
   endtask

   // only with the block idle
   task automatic set_mode(input bit m);
      logic [31:0] d;
      drain();
      d = $urandom;
      d[0] = m;
      csr_write(CSR_INVERSE_MODE, d);
      vector_model.inverse_mode = m;
      cur_mode = m;
      csr_check(CSR_INVERSE_MODE, 32'(m));
   endtask

   task automatic mixed_item();
      int r;
      r = $urandom_range(0, 99);
      if (r == 0 && transforms_left > 0) begin
         transforms_left--;
         send_item(OP_TRANSFORM, 10'($urandom), VALUE_W'($urandom));
      end else if (r < 47) begin
         send_item(OP_WRITE, 10'($urandom), rand_value());
      end else if (r < 94) begin
         send_item(OP_READ, 10'($urandom), VALUE_W'($urandom));
      end else begin
         send_item(OP_UNUSED, 10'($urandom), VALUE_W'($urandom));
      end
   endtask

   initial begin
      vector_model = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_check(CSR_INVERSE_MODE, 32'd0);

      // edges of index and value, unreduced values, unused opcode
      send_item(OP_WRITE, 10'd0, '0);
      send_item(OP_WRITE, 10'h3FF, MOD_P - 30'd1);
      send_item(OP_WRITE, 10'h200, MOD_P);
      send_item(OP_WRITE, 10'd1, VALUE_MAX);
      send_item(OP_WRITE, 10'h155, 30'h2AAA_AAAA);
      send_item(OP_WRITE, 10'h2AA, 30'h1555_5555);
      send_item(OP_UNUSED, 10'h3FF, VALUE_MAX);
      send_item(OP_READ, 10'd0, '0);
      send_item(OP_READ, 10'h3FF, VALUE_MAX);
      send_item(OP_READ, 10'h200, '0);
      send_item(OP_READ, 10'd1, '0);
      send_item(OP_READ, 10'h155, '0);
      send_item(OP_READ, 10'h2AA, '0);
      send_item(OP_WRITE, 10'd0, 30'd5);
      send_item(OP_READ, 10'd0, VALUE_MAX);
      send_item(OP_UNUSED, 10'd0, '0);

      // whole vector must hold data before any transform
      for (int i = 0; i < SIZE; i++) begin
         if (!written[i]) send_item(OP_WRITE, 10'(i), rand_value());
      end

      send_item(OP_TRANSFORM, 10'($urandom), VALUE_W'($urandom));
      send_item(OP_READ, 10'd0, '0);
      send_item(OP_READ, 10'h3FF, '0);
      set_mode(1'b1);
      // scaled transform undoes the plain one
      send_item(OP_TRANSFORM, 10'($urandom), VALUE_W'($urandom));
      send_item(OP_READ, 10'd0, '0);
      send_item(OP_READ, 10'h3FF, '0);

      transforms_left = TRANSFORM_BUDGET;
      for (int phase = 0; phase < MIXED_PHASES; phase++) begin
         set_mode(phase[0]);
         for (int n = 0; n < MIXED_PHASE_ITEMS; n++) begin
            mixed_item();
            if ($urandom_range(0, 49) == 0) drain();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d writes, %0d reads, %0d unused-opcode transactions,", n_write,
               n_read, n_unused);
      $display("%0d plain and %0d scaled transforms, %0d replies checked, %0d mode writes",
               n_plain_tf, n_scaled_tf, vector_model.checked, n_csr_write);
      if (vector_model.errors == 0 && csr_errors == 0 && vector_model.pending() == 0) begin
         $display("walsh_hadamard_transform_mod_prime_core: match");
      end else begin
         $display("walsh_hadamard_transform_mod_prime_core: mismatch");
      end
      $finish;
   end

endmodule

// File: walsh_hadamard_transform_mod_prime_core.f
rtl/core/wht_pkg.sv
rtl/core/wht_modmul.sv
rtl/core/walsh_hadamard_transform_mod_prime_core.sv
dv/wht_check_pkg.sv
dv/tb_walsh_hadamard_transform_mod_prime_core.sv
